@@ hdl/kbb_pkg.sv @@
// ----------------------------------------------------------------------------
// kbb_pkg: shared definitions for the knapsack branch-and-bound core
// Widths, register indexes, the sequencer state type and the divider request
// layout used by the core and its serial divider.
// ----------------------------------------------------------------------------
package kbb_pkg;

  localparam int unsigned MaxItems = 16;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CapW     = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValW     = 20;
  localparam int unsigned BoundW   = 21;
  localparam int unsigned DivW     = 20;
  localparam int unsigned DivCntW  = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  localparam logic CfgCapacity  = 1'b0;
  localparam logic CfgItemCount = 1'b1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef enum logic [13:0] {
    StIdle    = 14'b00000000000001,
    StEnter   = 14'b00000000000010,
    StTStart  = 14'b00000000000100,
    StTWait   = 14'b00000000001000,
    StMulW    = 14'b00000000010000,
    StMulV    = 14'b00000000100000,
    StAddV    = 14'b00000001000000,
    StEval    = 14'b00000010000000,
    StNextRd  = 14'b00000100000000,
    StMulB    = 14'b00001000000000,
    StBStart  = 14'b00010000000000,
    StBWait   = 14'b00100000000000,
    StNext    = 14'b01000000000000,
    StEmit    = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [ByteW-1:0] den;
  } div_req_t;

endpackage

@@ hdl/kbb_div.sv @@
// ----------------------------------------------------------------------------
// kbb_div: serial restoring divider
// Divides a 20-bit numerator by an 8-bit nonzero divisor, one quotient bit
// per cycle; done_o pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module kbb_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kbb_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [kbb_pkg::DivW-1:0] quot_o
);
  import kbb_pkg::*;

  logic [DivW-1:0]    q_q, q_d;
  logic [ByteW-1:0]   rem_q, rem_d;
  logic [ByteW-1:0]   den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ByteW:0]     trial;
  logic [ByteW:0]     diff;
  logic               ge;

  assign trial = {rem_q, q_q[DivW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      q_d    = req_i.num;
      rem_d  = '0;
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d   = {q_q[DivW-2:0], ge};
      rem_d = ge ? diff[ByteW-1:0] : trial[ByteW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

@@ hdl/knapsack_branch_and_bound_core.sv @@
// ----------------------------------------------------------------------------
// knapsack_branch_and_bound_core: unbounded knapsack search engine
// Loads (weight, value) pairs into a table, then runs a depth-first
// branch-and-bound search and streams out the best counts per item.
//
//   Channel   Direction  Contents (low bits first)
//   s_axis    in         tuser: operation; tdata: index, weight, value
//   m_axis    out        tdata: index, count, total value, total weight;
//                        tlast: final item
//   cfg       in         capacity (index 0), item count (index 1)
//
// A load request writes one table entry. A start request runs the search: each
// tried count at a level is evaluated and then stepped down, entering a level
// asks the serial divider for the largest count that fits, and each bound test waits on it too.
// Results then leave one per cycle while the output side is ready.
// s_axis_tready is low from a start with a nonzero item count until the last result is taken.
// Reset returns the sequencer to idle, clears the search state and solution and sets capacity to 8
// and item count to 4; the table and datapath registers are not reset.
module knapsack_branch_and_bound_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // item_index[3:0], item_weight[11:4], item_value[19:12], zero pad
  input  logic [kbb_pkg::InDataW-1:0]   s_axis_tdata,
  // operation
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_index[3:0], out_count[15:4], best_total_value[35:16],
  // best_total_weight[47:36]
  output logic [kbb_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [kbb_pkg::CapW-1:0]      cfg_data_i
);
  import kbb_pkg::*;

  state_e state_q, state_d;

  logic [ByteW-1:0]  wt_tbl [MaxItems];
  logic [ByteW-1:0]  val_tbl [MaxItems];
  logic [CapW-1:0]   cur_q [MaxItems];
  logic [CapW-1:0]   best_q [MaxItems];

  logic [CapW-1:0]   cap_q;
  logic [CountW-1:0] icnt_q;
  logic [CountW-1:0] active_q;
  logic [LevelW-1:0] level_q;
  logic [LevelW-1:0] emit_q;
  logic [CapW-1:0]   rw_q;
  logic [ValW-1:0]   rv_q;
  logic [ValW-1:0]   bv_q;
  logic [CapW-1:0]   bw_q;
  logic [ByteW-1:0]  w_q, v_q, nw_q, nv_q;
  logic [CapW-1:0]   top_q;
  logic [ValW-1:0]   prod_q;

  logic [LevelW-1:0] tbl_addr;
  logic [ByteW-1:0]  tbl_w, tbl_v;
  logic [CapW-1:0]   room;
  logic [ByteW-1:0]  mul_a;
  logic [CapW-1:0]   mul_b;
  logic [BoundW-1:0] bound;
  logic              is_last_level;
  logic              accept;
  logic [CountW-1:0] active_new;
  div_req_t          div_req;
  logic              div_done;
  logic [DivW-1:0]   div_quot;

  kbb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign active_new    = (icnt_q > CountW'(MaxItems)) ? CountW'(MaxItems) : icnt_q;

  assign tbl_addr = (state_q == StNextRd) ? level_q + 1'b1 : level_q;
  assign tbl_w    = (wt_tbl[tbl_addr] == '0) ? ByteW'(1) : wt_tbl[tbl_addr];
  assign tbl_v    = val_tbl[tbl_addr];
  assign room     = cap_q - rw_q;
  assign is_last_level = ({1'b0, level_q} + 1'b1) == active_q;
  assign bound    = {1'b0, rv_q} + {1'b0, div_quot};

  // The one multiplier serves w*top, v*top and the bound numerator.
  always_comb begin
    mul_a = w_q;
    mul_b = top_q;
    case (state_q)
      StMulV:  mul_b = top_q;
      StMulB:  mul_b = room;
      default: mul_b = top_q;
    endcase
    case (state_q)
      StMulV:  mul_a = v_q;
      StMulB:  mul_a = nv_q;
      default: mul_a = w_q;
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {{(DivW-CapW){1'b0}}, room};
    div_req.den   = w_q;
    case (state_q)
      StTStart: div_req.start = 1'b1;
      StBStart: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q;
        div_req.den   = nw_q;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && s_axis_tuser == OpStart && active_new != '0) begin
          state_d = StEnter;
        end
      end
      StEnter:  state_d = StTStart;
      StTStart: state_d = StTWait;
      StTWait:  if (div_done) state_d = StMulW;
      StMulW:   state_d = StMulV;
      StMulV:   state_d = StAddV;
      StAddV:   state_d = StEval;
      StEval:   state_d = is_last_level ? StNext : StNextRd;
      StNextRd: state_d = StMulB;
      StMulB:   state_d = StBStart;
      StBStart: state_d = StBWait;
      StBWait: begin
        if (div_done) begin
          state_d = (bound > {1'b0, bv_q}) ? StEnter : StNext;
        end
      end
      StNext: begin
        if (cur_q[level_q] == '0) begin
          // Level exhausted: climb back up, or finish at the root.
          state_d = (level_q == '0) ? StEmit : StNext;
        end else begin
          state_d = StEval;
        end
      end
      StEmit: begin
        if (m_axis_tready && ({1'b0, emit_q} + 1'b1) == active_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cap_q    <= CapW'(8);
      icnt_q   <= CountW'(4);
      active_q <= '0;
      level_q  <= '0;
      emit_q   <= '0;
      rw_q     <= '0;
      rv_q     <= '0;
      bv_q     <= '0;
      bw_q     <= '0;
      for (int i = 0; i < MaxItems; i++) begin
        cur_q[i]  <= '0;
        best_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCapacity:  cap_q  <= cfg_data_i;
          CfgItemCount: icnt_q <= cfg_data_i[CountW-1:0];
          default:      cap_q  <= cap_q;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (accept && s_axis_tuser == OpStart) begin
            active_q <= active_new;
            level_q  <= '0;
            emit_q   <= '0;
            rw_q     <= '0;
            rv_q     <= '0;
            bv_q     <= '0;
            bw_q     <= '0;
            for (int i = 0; i < MaxItems; i++) begin
              cur_q[i]  <= '0;
              best_q[i] <= '0;
            end
          end
        end
        StMulV: begin
          rw_q           <= rw_q + prod_q[CapW-1:0];
          cur_q[level_q] <= top_q;
        end
        StAddV: rv_q <= rv_q + prod_q;
        StEval: begin
          if (is_last_level && rv_q > bv_q) begin
            bv_q <= rv_q;
            bw_q <= rw_q;
            for (int i = 0; i < MaxItems; i++) begin
              best_q[i] <= cur_q[i];
            end
          end
        end
        StBWait: begin
          if (div_done && bound > {1'b0, bv_q}) begin
            level_q <= level_q + 1'b1;
          end
        end
        StNext: begin
          if (cur_q[level_q] == '0) begin
            if (level_q != '0) begin
              level_q <= level_q - 1'b1;
            end
          end else begin
            cur_q[level_q] <= cur_q[level_q] - 1'b1;
            rw_q           <= rw_q - {{(CapW-ByteW){1'b0}}, w_q};
            rv_q           <= rv_q - {{(ValW-ByteW){1'b0}}, v_q};
          end
        end
        StEmit: begin
          if (m_axis_tready) begin
            emit_q <= emit_q + 1'b1;
          end
        end
        default: level_q <= level_q;
      endcase
    end
  end

  // Table and datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == OpLoad) begin
      wt_tbl[s_axis_tdata[LevelW-1:0]]  <= s_axis_tdata[LevelW+ByteW-1:LevelW];
      val_tbl[s_axis_tdata[LevelW-1:0]] <= s_axis_tdata[LevelW+2*ByteW-1:LevelW+ByteW];
    end
    if (state_q == StEnter) begin
      w_q <= tbl_w;
      v_q <= tbl_v;
    end
    // After climbing back, the parent's unit weight and value are reloaded.
    if (state_q == StNext && cur_q[level_q] == '0 && level_q != '0) begin
      w_q <= (wt_tbl[level_q - 1'b1] == '0) ? ByteW'(1) : wt_tbl[level_q - 1'b1];
      v_q <= val_tbl[level_q - 1'b1];
    end
    if (state_q == StNextRd) begin
      nw_q <= tbl_w;
      nv_q <= tbl_v;
    end
    if (state_q == StTWait && div_done) begin
      top_q <= div_quot[CapW-1:0];
    end
    if (state_q == StMulW || state_q == StMulV || state_q == StMulB) begin
      prod_q <= ValW'(mul_a) * ValW'(mul_b);
    end
  end

  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tlast  = ({1'b0, emit_q} + 1'b1) == active_q;
  assign m_axis_tdata  = {bw_q, bv_q, best_q[emit_q], emit_q};

endmodule
